/* src/hrlp_pkg.sv */
// hrlp_pkg: shared types, character codes and match tables for the
// request line parser; no dependencies
package hrlp_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_TSTART  = 3'd1,
		PH_PATH    = 3'd2,
		PH_QUERY   = 3'd3,
		PH_VERSION = 3'd4,
		PH_SKIP    = 3'd5
	} phase_t;

	// status codes reported with the line end
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_TARGET  = 3'd1,
		ST_QUOTE       = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_BAD_METHOD  = 3'd4
	} status_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	localparam logic [2:0] METHOD_LEN  = 3'd4;
	localparam logic [3:0] VERSION_LEN = 4'd10;
	// bytes of the version seen just before its closing LF
	localparam logic [3:0] VERSION_PRE_LF = 4'd9;

	// one parser result
	typedef struct packed {
		logic [7:0] out_byte;
		logic       path_valid;
		logic       query_valid;
		logic       line_done;
		status_t    status;
	} result_t;

	// expected method text "GET "
	function automatic logic [7:0] method_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = 8'h47;
			2'd1:    c = 8'h45;
			2'd2:    c = 8'h54;
			default: c = CH_SPACE;
		endcase
		return c;
	endfunction

	// expected version text "HTTP/1.1\r\n"
	function automatic logic [7:0] version_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = 8'h48;
			4'd1:    c = 8'h54;
			4'd2:    c = 8'h54;
			4'd3:    c = 8'h50;
			4'd4:    c = 8'h2F;
			4'd5:    c = 8'h31;
			4'd6:    c = 8'h2E;
			4'd7:    c = 8'h31;
			4'd8:    c = CH_CR;
			4'd9:    c = CH_LF;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* src/hrlp_core.sv */
// hrlp_core: parser state registers and the single-byte step logic
// depends on hrlp_pkg
module hrlp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        byte_in,
	output hrlp_pkg::result_t res
);
	import hrlp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] method_pos_q, method_pos_d;
	logic       method_ok_q, method_ok_d;
	logic [3:0] version_pos_q, version_pos_d;
	logic       version_ok_q, version_ok_d;
	logic       target_bad_q, target_bad_d;
	logic       quote_seen_q, quote_seen_d;

	logic is_lf;
	assign is_lf = (byte_in == CH_LF);

	// next state
	always_comb begin
		phase_d       = phase_q;
		method_pos_d  = method_pos_q;
		method_ok_d   = method_ok_q;
		version_pos_d = version_pos_q;
		version_ok_d  = version_ok_q;
		target_bad_d  = target_bad_q;
		quote_seen_d  = quote_seen_q;
		if (is_lf) begin
			phase_d       = PH_METHOD;
			method_pos_d  = '0;
			method_ok_d   = 1'b1;
			version_pos_d = '0;
			version_ok_d  = 1'b1;
			target_bad_d  = 1'b0;
			quote_seen_d  = 1'b0;
		end else begin
			case (phase_q)
				PH_METHOD: begin
					if (method_pos_q < METHOD_LEN) begin
						if (byte_in != method_char(method_pos_q[1:0]))
							method_ok_d = 1'b0;
						method_pos_d = method_pos_q + 3'd1;
					end
					if (byte_in == CH_SPACE)
						phase_d = PH_TSTART;
				end
				PH_TSTART: begin
					if (byte_in == CH_SLASH) begin
						phase_d = PH_PATH;
					end else begin
						target_bad_d = 1'b1;
						phase_d      = PH_SKIP;
					end
				end
				PH_PATH: begin
					if (byte_in == CH_QMARK)
						phase_d = PH_QUERY;
					else if (byte_in == CH_SPACE)
						phase_d = PH_VERSION;
				end
				PH_QUERY: begin
					if (byte_in == CH_SPACE)
						phase_d = PH_VERSION;
					else if (byte_in == CH_QUOTE)
						quote_seen_d = 1'b1;
				end
				PH_VERSION: begin
					if (version_pos_q < VERSION_LEN) begin
						if (byte_in != version_char(version_pos_q))
							version_ok_d = 1'b0;
						version_pos_d = version_pos_q + 4'd1;
					end else begin
						version_ok_d = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// result for this byte
	always_comb begin
		logic tbad, vgood, mgood;
		tbad  = target_bad_q || (phase_q == PH_METHOD) || (phase_q == PH_TSTART)
			|| (phase_q > PH_VERSION);
		vgood = (phase_q == PH_VERSION) && version_ok_q
			&& (version_pos_q == VERSION_PRE_LF);
		mgood = method_ok_q && (method_pos_q >= METHOD_LEN);
		res             = '0;
		res.status      = ST_OK;
		res.path_valid  = 1'b0;
		res.query_valid = 1'b0;
		if (is_lf) begin
			res.line_done = 1'b1;
			if (tbad)
				res.status = ST_BAD_TARGET;
			else if (quote_seen_q)
				res.status = ST_QUOTE;
			else if (!vgood)
				res.status = ST_BAD_VERSION;
			else if (!mgood)
				res.status = ST_BAD_METHOD;
			else
				res.status = ST_OK;
		end else begin
			case (phase_q)
				PH_TSTART: res.path_valid  = (byte_in == CH_SLASH);
				PH_PATH:   res.path_valid  = (byte_in != CH_QMARK) && (byte_in != CH_SPACE);
				PH_QUERY:  res.query_valid = (byte_in != CH_SPACE);
				default:   ;
			endcase
		end
		res.out_byte = (res.path_valid || res.query_valid) ? byte_in : 8'h00;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_METHOD;
			method_pos_q  <= '0;
			method_ok_q   <= 1'b1;
			version_pos_q <= '0;
			version_ok_q  <= 1'b1;
			target_bad_q  <= 1'b0;
			quote_seen_q  <= 1'b0;
		end else if (step_en) begin
			phase_q       <= phase_d;
			method_pos_q  <= method_pos_d;
			method_ok_q   <= method_ok_d;
			version_pos_q <= version_pos_d;
			version_ok_q  <= version_ok_d;
			target_bad_q  <= target_bad_d;
			quote_seen_q  <= quote_seen_d;
		end
	end

endmodule

/* src/http_request_line_parser_unit.sv */
// http_request_line_parser_unit: top level, input and result registers
// around hrlp_core; depends on hrlp_pkg and hrlp_core
//
// Usage:
//   s_* carries the request line, one byte per transaction in s_tdata.
//   m_* gives one result transaction per input byte: m_tdata holds the
//   echoed path or query byte (zero otherwise) and the status, m_tuser
//   marks path and query bytes, m_tlast marks the LF that ends the line;
//   status is nonzero only with m_tlast.
//   Path: a byte accepted into the input register is stepped through the
//   parser into the result register and shown on m_* from then on.
//   Throughput: one byte per cycle while m_* is not stalled; the parser
//   step is one short compare-and-select path between the input and
//   result registers.
//   Reset clears the valid flags of both registers and returns the parser
//   to the method phase.
//   When a result waits and m_tready is low, the result register holds, the
//   input register still takes one more byte if it is empty, and then s_tready
//   drops until the result is taken.
module http_request_line_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, rest zero
	output logic [1:0]  m_tuser,   // [0] path_valid, [1] query_valid
	output logic        m_tlast    // line_done
);
	import hrlp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       advance;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	hrlp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (valid_s1 && advance),
		.byte_in (byte_s1),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.status, res_s2.out_byte};
	assign m_tuser  = {res_s2.query_valid, res_s2.path_valid};
	assign m_tlast  = res_s2.line_done;

	// a result is never both path and query
	a_excl_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.path_valid && res_s2.query_valid))
		else $error("path and query flags both set");

	// status only reported with the line end
	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.line_done) |-> (res_s2.status == ST_OK))
		else $error("status set without line end");

	// the line end never carries a captured byte
	a_last_no_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.line_done) |->
			(!res_s2.path_valid && !res_s2.query_valid && res_s2.out_byte == 8'h00))
		else $error("line end marked as captured byte");

	// a stalled result register keeps its content
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |=> (valid_s2 && $stable(res_s2)))
		else $error("result changed under stall");

endmodule

/* sim/http_request_line_parser_unit_test.sv */
// testbench for http_request_line_parser_unit: random request lines with stream
// stalls, checked against a cycle-free parser model; depends on hrlp_pkg and the unit
`timescale 1ns / 100ps

module http_request_line_parser_unit_test;
	import hrlp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_BYTES = 775;

	localparam logic [7:0] GET_TEXT [4] = '{8'h47, 8'h45, 8'h54, 8'h20};
	localparam logic [7:0] HTTP11_TEXT [10] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F,
		8'h31, 8'h2E, 8'h31, 8'h0D, 8'h0A};

	// one byte waiting to be sent; wait_idle holds it back until all results are in
	typedef struct packed {
		logic [7:0] data;
		logic       wait_idle;
	} feed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] out_byte, [10:8] status, rest zero
	logic [1:0]  m_tuser;           // [0] path_valid, [1] query_valid
	logic        m_tlast;           // line_done

	feed_t   line_feed[$];
	result_t expected_results[$];
	int      mismatches = 0;
	int      queued_bytes = 0;
	int      results_taken = 0;
	logic    pause_armed = 1'b0;

	// parser state mirrored by the predictor
	phase_t     parse_phase = PH_METHOD;
	logic [2:0] method_seen = '0;
	logic       method_match = 1'b1;
	logic [3:0] version_seen = '0;
	logic       version_match = 1'b1;
	logic       target_bad_flag = 1'b0;
	logic       quote_flag = 1'b0;

	http_request_line_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// advance the parser by one byte and give the result it must produce
	function automatic result_t parse_step(input logic [7:0] b);
		result_t r;
		logic pv, qv, tbad, vgood, mgood;
		r = '0;
		pv = 1'b0;
		qv = 1'b0;
		if (b == CH_LF) begin
			tbad = target_bad_flag || (parse_phase != PH_PATH && parse_phase != PH_QUERY
				&& parse_phase != PH_VERSION);
			vgood = parse_phase == PH_VERSION && version_match && version_seen == 4'd9;
			mgood = method_match && method_seen >= 3'd4;
			r.line_done = 1'b1;
			if (tbad)
				r.status = ST_BAD_TARGET;
			else if (quote_flag)
				r.status = ST_QUOTE;
			else if (!vgood)
				r.status = ST_BAD_VERSION;
			else if (!mgood)
				r.status = ST_BAD_METHOD;
			else
				r.status = ST_OK;
			parse_phase = PH_METHOD;
			method_seen = '0;
			method_match = 1'b1;
			version_seen = '0;
			version_match = 1'b1;
			target_bad_flag = 1'b0;
			quote_flag = 1'b0;
		end else begin
			case (parse_phase)
				PH_METHOD: begin
					if (method_seen < 3'd4) begin
						if (b != GET_TEXT[method_seen[1:0]])
							method_match = 1'b0;
						method_seen = method_seen + 3'd1;
					end
					if (b == CH_SPACE)
						parse_phase = PH_TSTART;
				end
				PH_TSTART: begin
					if (b == CH_SLASH) begin
						pv = 1'b1;
						parse_phase = PH_PATH;
					end else begin
						target_bad_flag = 1'b1;
						parse_phase = PH_SKIP;
					end
				end
				PH_PATH: begin
					if (b == CH_QMARK)
						parse_phase = PH_QUERY;
					else if (b == CH_SPACE)
						parse_phase = PH_VERSION;
					else
						pv = 1'b1;
				end
				PH_QUERY: begin
					if (b == CH_SPACE) begin
						parse_phase = PH_VERSION;
					end else begin
						if (b == CH_QUOTE)
							quote_flag = 1'b1;
						qv = 1'b1;
					end
				end
				PH_VERSION: begin
					if (version_seen < 4'd10) begin
						if (b != HTTP11_TEXT[version_seen])
							version_match = 1'b0;
						version_seen = version_seen + 4'd1;
					end else begin
						version_match = 1'b0;
					end
				end
				default: ;
			endcase
		end
		r.out_byte = (pv || qv) ? b : 8'h00;
		r.path_valid = pv;
		r.query_valid = qv;
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// random byte, never LF, optionally never space or question mark
	function automatic logic [7:0] pick_byte(input bit no_space, input bit no_qmark);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_LF || (no_space && b == CH_SPACE) || (no_qmark && b == CH_QMARK));
		return b;
	endfunction

	task automatic feed_byte(input logic [7:0] b);
		feed_t f;
		f.data = b;
		f.wait_idle = pause_armed;
		pause_armed = 1'b0;
		line_feed.push_back(f);
		queued_bytes++;
	endtask

	task automatic feed_text(input logic [7:0] part[$]);
		foreach (part[i])
			feed_byte(part[i]);
	endtask

	// one request line, mostly well formed, sometimes broken in one or more places
	task automatic queue_request_line();
		logic [7:0] part[$];
		int n;
		int pos;
		int pick;
		// pure noise line
		if ($urandom_range(0, 99) < 5) begin
			n = $urandom_range(1, 12);
			repeat (n) feed_byte(8'($urandom_range(0, 255)));
			feed_byte(CH_LF);
			return;
		end
		// method, occasionally with one byte replaced, dropped or added
		part = {GET_TEXT[0], GET_TEXT[1], GET_TEXT[2], GET_TEXT[3]};
		if ($urandom_range(0, 99) < 12) begin
			pos = $urandom_range(0, 3);
			pick = $urandom_range(0, 2);
			if (pick == 0)
				part[pos] = pick_byte(1'b0, 1'b0);
			else if (pick == 1)
				part.delete(pos);
			else
				part.insert(pos, pick_byte(1'b1, 1'b0));
		end
		feed_text(part);
		// target start
		if ($urandom_range(0, 99) < 8)
			feed_byte(8'($urandom_range(0, 255)));
		else
			feed_byte(CH_SLASH);
		// path
		n = $urandom_range(0, 8);
		repeat (n) feed_byte(pick_byte(1'b1, 1'b1));
		if ($urandom_range(0, 99) < 5) begin
			feed_byte(CH_LF);
			return;
		end
		// query with the odd quote or question mark
		if ($urandom_range(0, 99) < 45) begin
			feed_byte(CH_QMARK);
			n = $urandom_range(0, 6);
			repeat (n) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					feed_byte(CH_QUOTE);
				else if (pick == 1)
					feed_byte(CH_QMARK);
				else
					feed_byte(pick_byte(1'b1, 1'b0));
			end
			if ($urandom_range(0, 99) < 4) begin
				feed_byte(CH_LF);
				return;
			end
		end
		// version up to the CR, then the closing LF
		feed_byte(CH_SPACE);
		part = {HTTP11_TEXT[0], HTTP11_TEXT[1], HTTP11_TEXT[2], HTTP11_TEXT[3],
			HTTP11_TEXT[4], HTTP11_TEXT[5], HTTP11_TEXT[6], HTTP11_TEXT[7], HTTP11_TEXT[8]};
		if ($urandom_range(0, 99) < 15) begin
			pos = $urandom_range(0, 8);
			pick = $urandom_range(0, 2);
			if (pick == 0)
				part[pos] = $urandom_range(0, 1) ? CH_QMARK : pick_byte(1'b0, 1'b0);
			else if (pick == 1)
				part.delete(pos);
			else
				part.insert(pos, pick_byte(1'b0, 1'b0));
		end
		feed_text(part);
		feed_byte(CH_LF);
	endtask

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : send_bytes
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			burst_left = 0;
			gap_left = 0;
		end else begin
			// retire the accepted transaction
			if (s_tvalid && s_tready) begin
				expected_results.push_back(parse_step(s_tdata));
				void'(line_feed.pop_front());
			end
			// offer the next byte, or hold the one still pending
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (line_feed.size() != 0 &&
				!(line_feed[0].wait_idle && expected_results.size() != 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= line_feed[0].data;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: check results and stall in stretches of varying density
	int   stretch_left = 0;
	int   ready_pct = 100;
	int   hold_left = 0;
	logic long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin : take_results
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_taken++;
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction: out_byte %0h, status %0d",
						m_tdata[7:0], m_tdata[10:8]);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					compare_field("out_byte", want.out_byte, m_tdata[7:0]);
					compare_field("status", 8'(want.status), 8'(m_tdata[10:8]));
					compare_field("path_valid", 8'(want.path_valid), 8'(m_tuser[0]));
					compare_field("query_valid", 8'(want.query_valid), 8'(m_tuser[1]));
					compare_field("line_done", 8'(want.line_done), 8'(m_tlast));
				end
			end
			// one long hold-off so the unit backs up into its input
			if (!long_hold_done && results_taken >= 250) begin
				long_hold_done = 1'b1;
				hold_left = 200;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(8, 60);
					case ($urandom_range(0, 3))
						0: ready_pct = 100;
						1: ready_pct = 80;
						2: ready_pct = 50;
						default: ready_pct = 20;
					endcase
				end
				stretch_left--;
				m_tready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : run
		logic pause_placed;
		pause_placed = 1'b0;
		// directed lines: LF alone, bad target with extreme bytes, empty query
		feed_byte(CH_LF);
		feed_text({GET_TEXT[0], GET_TEXT[1], GET_TEXT[2], GET_TEXT[3], 8'hFF, 8'h00, CH_LF});
		feed_text({GET_TEXT[0], GET_TEXT[1], GET_TEXT[2], GET_TEXT[3], CH_SLASH, CH_QMARK,
			CH_SPACE});
		foreach (HTTP11_TEXT[i])
			feed_byte(HTTP11_TEXT[i]);
		// random lines, one of them sent only once the unit has drained
		while (queued_bytes < RANDOM_BYTES) begin
			if (!pause_placed && queued_bytes >= 450) begin
				pause_armed = 1'b1;
				pause_placed = 1'b1;
			end
			queue_request_line();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (line_feed.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
